[rtl/core/selt_pkg.sv]
// Package for the shared/exclusive lock table.
// Fixed field widths, request mode and verdict codes, and the lookup status struct.
// No dependencies.
`timescale 1ns / 1ps

package selt_pkg;

    localparam int OPCODE_W   = 1;
    localparam int TRANS_ID_W = 4;
    localparam int ITEM_KEY_W = 32;
    localparam int VERDICT_W  = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SHARED    = 1'b0,
        OP_EXCLUSIVE = 1'b1
    } opcode_t;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_GRANTED = 2'd0,
        VERDICT_DENIED  = 2'd1,
        VERDICT_IGNORED = 2'd2,
        VERDICT_FULL    = 2'd3
    } verdict_t;

    // Outcome of the associative lookup against the table.
    typedef struct packed {
        logic hit;
        logic full;
    } lookup_status_t;

endpackage

[rtl/core/selt_if.sv]
// Request and response channel interfaces for the lock table.
// Depends on selt_pkg for the field widths.
`timescale 1ns / 1ps

interface selt_req_if;
    logic                                valid;
    logic                                ready;
    logic [selt_pkg::OPCODE_W-1:0]       opcode;
    logic [selt_pkg::TRANS_ID_W-1:0]     trans_id;
    logic [selt_pkg::ITEM_KEY_W-1:0]     item_key;

    modport source (output valid, output opcode, output trans_id, output item_key,
                    input ready);
    modport sink   (input valid, input opcode, input trans_id, input item_key,
                    output ready);
endinterface

interface selt_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [selt_pkg::VERDICT_W-1:0]      verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

[rtl/core/selt_match.sv]
// Associative lookup over the lock table: key match, lowest free entry and
// the holder bitmaps of the matching entry. Depends on selt_pkg.
`timescale 1ns / 1ps

module selt_match #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32,
    parameter int TRANS    = 16
) (
    input  logic [KEY_BITS-1:0]   key,
    input  logic [ENTRIES-1:0]    entry_valid,
    input  logic [KEY_BITS-1:0]   entry_key [ENTRIES],
    input  logic [TRANS-1:0]      shared_holders [ENTRIES],
    input  logic [TRANS-1:0]      exclusive_holders [ENTRIES],
    output selt_pkg::lookup_status_t status,
    output logic [ENTRIES-1:0]    hit_onehot,
    output logic [ENTRIES-1:0]    free_onehot,
    output logic [TRANS-1:0]      shared_sel,
    output logic [TRANS-1:0]      exclusive_sel
);
    import selt_pkg::*;

    logic [ENTRIES-1:0] key_eq;

    always_comb
    begin
        for (int e = 0; e < ENTRIES; e++)
        begin
            key_eq[e] = (entry_key[e] == key);
        end
    end

    // Valid keys are unique, so at most one entry hits.
    assign hit_onehot = entry_valid & key_eq;
    // Lowest clear bit of the valid vector.
    assign free_onehot = ~entry_valid & (entry_valid + ENTRIES'(1));

    always_comb
    begin
        shared_sel    = '0;
        exclusive_sel = '0;
        for (int e = 0; e < ENTRIES; e++)
        begin
            shared_sel    = shared_sel    | ({TRANS{hit_onehot[e]}} & shared_holders[e]);
            exclusive_sel = exclusive_sel | ({TRANS{hit_onehot[e]}} & exclusive_holders[e]);
        end
    end

    assign status.hit  = |hit_onehot;
    assign status.full = &entry_valid;

endmodule

[rtl/core/shared_exclusive_lock_table.sv]
// Shared/exclusive lock table: one verdict per lock request.
// Pipeline: the accepted request is held in the request register, then lookup and
// table update feed the verdict register.
// Throughput: one request per cycle when not stalled by rsp.ready; the table update
// lands on the same edge as the verdict, so the next request already sees it.
// Reset (async, rst_n low) clears valid bits, holder bitmaps and the abort map at once.
`timescale 1ns / 1ps

module shared_exclusive_lock_table #(
    parameter int NUM_TRANSACTIONS = 16,
    parameter int TABLE_ENTRIES    = 16,
    parameter int KEY_BITS         = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    selt_req_if.sink    req,
    selt_rsp_if.source  rsp
);
    import selt_pkg::*;

    localparam int TW = NUM_TRANSACTIONS;
    localparam int EN = TABLE_ENTRIES;

    // request stage
    logic                  req_valid_reg;
    opcode_t               op_reg;
    logic [TRANS_ID_W-1:0] tid_reg;
    logic [KEY_BITS-1:0]   key_reg;

    // table
    logic [EN-1:0]         entry_valid_reg;
    logic [KEY_BITS-1:0]   entry_key_reg [EN];
    logic [TW-1:0]         shared_reg [EN];
    logic [TW-1:0]         exclusive_reg [EN];
    logic [TW-1:0]         aborted_reg;

    // verdict stage
    logic                  rsp_valid_reg;
    verdict_t              verdict_reg;

    logic                  advance;
    logic                  load;
    logic                  fire;
    logic                  in_range;
    logic                  aborted;
    logic [TW-1:0]         me;
    logic [TW-1:0]         others;
    verdict_t              verdict_next;
    logic                  grant;

    lookup_status_t        status;
    logic [EN-1:0]         hit_onehot;
    logic [EN-1:0]         free_onehot;
    logic [EN-1:0]         target;
    logic [TW-1:0]         shared_sel;
    logic [TW-1:0]         exclusive_sel;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = !req_valid_reg || advance;
    assign load      = req.valid && req.ready;
    assign fire      = req_valid_reg && advance;

    selt_match #(
        .ENTRIES  (EN),
        .KEY_BITS (KEY_BITS),
        .TRANS    (TW)
    ) u_match (
        .key               (key_reg),
        .entry_valid       (entry_valid_reg),
        .entry_key         (entry_key_reg),
        .shared_holders    (shared_reg),
        .exclusive_holders (exclusive_reg),
        .status            (status),
        .hit_onehot        (hit_onehot),
        .free_onehot       (free_onehot),
        .shared_sel        (shared_sel),
        .exclusive_sel     (exclusive_sel)
    );

    assign in_range = (32'(tid_reg) < NUM_TRANSACTIONS);
    assign me       = TW'(1) << tid_reg;
    assign aborted  = |(aborted_reg & me);
    assign others   = (exclusive_sel | ((op_reg == OP_EXCLUSIVE) ? shared_sel : '0)) & ~me;

    always_comb
    begin
        if (!in_range || aborted)
        begin
            verdict_next = VERDICT_IGNORED;
        end
        else if (!status.hit)
        begin
            verdict_next = status.full ? VERDICT_FULL : VERDICT_GRANTED;
        end
        else if (others != '0)
        begin
            verdict_next = VERDICT_DENIED;
        end
        else
        begin
            verdict_next = VERDICT_GRANTED;
        end
    end

    assign grant  = fire && (verdict_next == VERDICT_GRANTED);
    assign target = status.hit ? hit_onehot : free_onehot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                req_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg  <= opcode_t'(req.opcode);
            tid_reg <= req.trans_id;
            key_reg <= KEY_BITS'(req.item_key);
        end
        if (fire)
        begin
            verdict_reg <= verdict_next;
        end
    end

    // Table and abort map update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            aborted_reg     <= '0;
            for (int e = 0; e < EN; e++)
            begin
                shared_reg[e]    <= '0;
                exclusive_reg[e] <= '0;
            end
        end
        else
        begin
            if (fire && (verdict_next == VERDICT_DENIED))
            begin
                aborted_reg <= aborted_reg | me;
            end
            for (int e = 0; e < EN; e++)
            begin
                if (grant && target[e])
                begin
                    entry_valid_reg[e] <= 1'b1;
                    // a fresh entry starts with empty bitmaps
                    shared_reg[e] <= (status.hit ? shared_reg[e] : '0)
                                     | ((op_reg == OP_SHARED) ? me : '0);
                    exclusive_reg[e] <= (status.hit ? exclusive_reg[e] : '0)
                                        | ((op_reg == OP_EXCLUSIVE) ? me : '0);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int e = 0; e < EN; e++)
        begin
            if (grant && !status.hit && free_onehot[e])
            begin
                entry_key_reg[e] <= key_reg;
            end
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.verdict = verdict_reg;

endmodule
